FILE: design/least_loaded_server_tracker_unit_defines.svh
// assertion macros for the least-loaded server tracker rtl
// expects clk and arst_n in the scope where a macro is used
`ifndef LEAST_LOADED_SERVER_TRACKER_UNIT_DEFINES_SVH
`define LEAST_LOADED_SERVER_TRACKER_UNIT_DEFINES_SVH

// antecedent holds, consequent in the same cycle
`define LLST_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// antecedent holds, consequent in the next cycle
`define LLST_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: design/llst_pkg.sv
// shared types and constants of the least-loaded server tracker
// no dependencies
package llst_pkg;

	localparam int IP_W          = 32;
	localparam int COUNT_W       = 32;
	localparam int SERVER_IDX_W  = 6;
	localparam int GROUP_IDX_W   = 4;
	localparam int QUEUE_DEPTH   = 2;

	typedef struct packed {
		logic [SERVER_IDX_W-1:0] server_index;
		logic [GROUP_IDX_W-1:0]  group_index;
		logic [COUNT_W-1:0]      server_count;
		logic [SERVER_IDX_W-1:0] best_server;
		logic [COUNT_W-1:0]      best_count;
		logic                    took_over;
	} result_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

endpackage

FILE: design/llst_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
module llst_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                                 clk,
	input  logic                                 we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                     wdata,
	input  logic                                 re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                     rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: design/llst_queue.sv
// short fifo between the index front end and the table back end
// depends on llst_pkg
module llst_queue #(
	parameter int WIDTH = 10
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  logic [WIDTH-1:0]    wdata,
	input  logic                pop,
	output logic [WIDTH-1:0]    rdata,
	output llst_pkg::q_status_t status
);

	localparam int DEPTH = llst_pkg::QUEUE_DEPTH;
	localparam int PTR_W = DEPTH > 1 ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] entry_q [DEPTH];
	logic [PTR_W-1:0] wptr_q;
	logic [PTR_W-1:0] rptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign status.full  = (count_q == CNT_W'(DEPTH));
	assign status.empty = (count_q == '0);
	assign do_push      = push && !status.full;
	assign do_pop       = pop && !status.empty;
	assign rdata        = entry_q[rptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wptr_q <= (wptr_q == PTR_W'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (do_pop) begin
				rptr_q <= (rptr_q == PTR_W'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

FILE: design/llst_front.sv
// front end: takes one address beat, reduces it modulo the server and
// group counts by reciprocal multiplication, and queues the two indices; uses llst_pkg
module llst_front #(
	parameter int SERVERS = 64,
	parameter int GROUPS  = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              push,
	input  logic [llst_pkg::IP_W-1:0]         dest_ip,
	input  logic                              clearing,
	output logic                              full,
	input  llst_pkg::q_status_t               q_status,
	output logic                              q_push,
	output logic [(SERVERS > 1 ? $clog2(SERVERS) : 1) + (GROUPS > 1 ? $clog2(GROUPS) : 1)-1:0]
	                                          q_data
);

	localparam int SRV_W = SERVERS > 1 ? $clog2(SERVERS) : 1;
	localparam int GRP_W = GROUPS > 1 ? $clog2(GROUPS) : 1;
	localparam int IP_W  = llst_pkg::IP_W;
	localparam int PRD_W = 2 * IP_W + 1;
	localparam int SRV_L = $clog2(SERVERS);
	localparam int GRP_L = $clog2(GROUPS);
	// m = ceil(2^(32+l) / d) with l = clog2(d) gives floor(x / d) for every 32-bit x
	localparam logic [PRD_W-1:0] SRV_NUM =
		(PRD_W'(1) << (IP_W + SRV_L)) + PRD_W'(SERVERS - 1);
	localparam logic [PRD_W-1:0] GRP_NUM =
		(PRD_W'(1) << (IP_W + GRP_L)) + PRD_W'(GROUPS - 1);
	localparam logic [IP_W:0]    SRV_M = (IP_W + 1)'(SRV_NUM / PRD_W'(SERVERS));
	localparam logic [IP_W:0]    GRP_M = (IP_W + 1)'(GRP_NUM / PRD_W'(GROUPS));
	localparam logic [IP_W-1:0]  SRV_D = IP_W'(SERVERS);
	localparam logic [IP_W-1:0]  GRP_D = IP_W'(GROUPS);

	typedef enum logic [1:0] {
		F_IDLE,
		F_MUL,
		F_SUB,
		F_PUSH
	} fstate_t;

	fstate_t          state_q;
	logic [IP_W-1:0]  ip_q;
	logic [IP_W-1:0]  squot_q;
	logic [IP_W-1:0]  gquot_q;
	logic [SRV_W-1:0] srem_q;
	logic [GRP_W-1:0] grem_q;
	logic [PRD_W-1:0] s_prod;
	logic [PRD_W-1:0] g_prod;
	logic [IP_W-1:0]  s_diff;
	logic [IP_W-1:0]  g_diff;
	logic             accept;

	assign full   = (state_q != F_IDLE) || clearing;
	assign accept = push && !full;
	assign q_push = (state_q == F_PUSH);
	assign q_data = {srem_q, grem_q};

	// 32 x 33 bit products, the upper bits of the operands are zero
	assign s_prod = PRD_W'(ip_q) * PRD_W'(SRV_M);
	assign g_prod = PRD_W'(ip_q) * PRD_W'(GRP_M);
	assign s_diff = ip_q - squot_q * SRV_D;
	assign g_diff = ip_q - gquot_q * GRP_D;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else begin
			case (state_q)
				F_IDLE: begin
					if (accept) begin
						state_q <= F_MUL;
					end
				end
				F_MUL: begin
					state_q <= F_SUB;
				end
				F_SUB: begin
					state_q <= F_PUSH;
				end
				F_PUSH: begin
					if (!q_status.full) begin
						state_q <= F_IDLE;
					end
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ip_q <= dest_ip;
		end
		if (state_q == F_MUL) begin
			squot_q <= IP_W'(s_prod >> (IP_W + SRV_L));
			gquot_q <= IP_W'(g_prod >> (IP_W + GRP_L));
		end
		if (state_q == F_SUB) begin
			srem_q <= s_diff[SRV_W-1:0];
			grem_q <= g_diff[GRP_W-1:0];
		end
	end

endmodule

FILE: design/llst_back.sv
// back end: clears the tables after reset, then does one read-modify-write
// of the server counter and group record per queued beat; uses llst_pkg, llst_ram
`include "least_loaded_server_tracker_unit_defines.svh"

module llst_back #(
	parameter int SERVERS = 64,
	parameter int GROUPS  = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  llst_pkg::q_status_t q_status,
	input  logic [(SERVERS > 1 ? $clog2(SERVERS) : 1) + (GROUPS > 1 ? $clog2(GROUPS) : 1)-1:0]
	                            q_data,
	output logic                q_pop,
	output logic                clearing,
	input  logic                pop,
	output logic                empty,
	output llst_pkg::result_t   result
);

	localparam int SRV_W = SERVERS > 1 ? $clog2(SERVERS) : 1;
	localparam int GRP_W = GROUPS > 1 ? $clog2(GROUPS) : 1;
	localparam int CNT_W = llst_pkg::COUNT_W;
	localparam int GE_W  = SRV_W + CNT_W;
	localparam int CLR_N = SERVERS > GROUPS ? SERVERS : GROUPS;
	localparam int CLR_W = $clog2(CLR_N + 1);

	typedef enum logic [1:0] {
		B_CLEAR,
		B_IDLE,
		B_EXEC
	} bstate_t;

	bstate_t           state_q;
	logic [CLR_W-1:0]  clr_q;
	logic [SRV_W-1:0]  srv_q;
	logic [GRP_W-1:0]  grp_q;
	logic              out_valid_q;
	llst_pkg::result_t res_q;

	logic              srv_we;
	logic [SRV_W-1:0]  srv_waddr;
	logic [CNT_W-1:0]  srv_wdata;
	logic [CNT_W-1:0]  srv_rdata;
	logic              grp_we;
	logic [GRP_W-1:0]  grp_waddr;
	logic [GE_W-1:0]   grp_wdata;
	logic [GE_W-1:0]   grp_rdata;

	logic [SRV_W-1:0]  head_srv;
	logic [GRP_W-1:0]  head_grp;
	logic [CNT_W-1:0]  cnt;
	logic [SRV_W-1:0]  g_srv;
	logic [CNT_W-1:0]  g_cnt;
	logic              took;
	logic              same;
	logic [SRV_W-1:0]  new_srv;
	logic [CNT_W-1:0]  new_cnt;
	logic              exec;

	assign {head_srv, head_grp} = q_data;
	assign clearing = (state_q == B_CLEAR);
	assign q_pop    = (state_q == B_IDLE) && !q_status.empty && !out_valid_q;
	assign exec     = (state_q == B_EXEC);
	assign empty    = !out_valid_q;
	assign result   = res_q;

	// counter update and group record decision
	assign cnt   = srv_rdata + 1'b1;
	assign g_srv = grp_rdata[GE_W-1:CNT_W];
	assign g_cnt = grp_rdata[CNT_W-1:0];
	assign took  = (cnt < g_cnt);
	assign same  = (srv_q == g_srv);

	always_comb begin
		new_srv = g_srv;
		new_cnt = g_cnt;
		if (took) begin
			new_srv = srv_q;
			new_cnt = cnt;
		end else if (same) begin
			new_cnt = cnt;
		end
	end

	// the clear sweep shares the write ports with the update
	always_comb begin
		if (clearing) begin
			srv_we    = (clr_q < CLR_W'(SERVERS));
			srv_waddr = clr_q[SRV_W-1:0];
			srv_wdata = '0;
			grp_we    = (clr_q < CLR_W'(GROUPS));
			grp_waddr = clr_q[GRP_W-1:0];
			grp_wdata = '0;
		end else begin
			srv_we    = exec;
			srv_waddr = srv_q;
			srv_wdata = cnt;
			grp_we    = exec;
			grp_waddr = grp_q;
			grp_wdata = {new_srv, new_cnt};
		end
	end

	llst_ram #(
		.WIDTH (CNT_W),
		.DEPTH (SERVERS)
	) u_srv_ram (
		.clk   (clk),
		.we    (srv_we),
		.waddr (srv_waddr),
		.wdata (srv_wdata),
		.re    (q_pop),
		.raddr (head_srv),
		.rdata (srv_rdata)
	);

	llst_ram #(
		.WIDTH (GE_W),
		.DEPTH (GROUPS)
	) u_grp_ram (
		.clk   (clk),
		.we    (grp_we),
		.waddr (grp_waddr),
		.wdata (grp_wdata),
		.re    (q_pop),
		.raddr (head_grp),
		.rdata (grp_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_CLEAR;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				B_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == CLR_W'(CLR_N - 1)) begin
						state_q <= B_IDLE;
					end
				end
				B_IDLE: begin
					if (q_pop) begin
						state_q <= B_EXEC;
					end
				end
				B_EXEC: begin
					state_q <= B_IDLE;
				end
				default: state_q <= B_IDLE;
			endcase
			if (exec) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			srv_q <= head_srv;
			grp_q <= head_grp;
		end
		if (exec) begin
			res_q.server_index <= llst_pkg::SERVER_IDX_W'(srv_q);
			res_q.group_index  <= llst_pkg::GROUP_IDX_W'(grp_q);
			res_q.server_count <= cnt;
			res_q.best_server  <= llst_pkg::SERVER_IDX_W'(new_srv);
			res_q.best_count   <= new_cnt;
			res_q.took_over    <= took;
		end
	end

	`LLST_ASSERT_SAME(a_no_start_in_clear, clearing, !q_pop, "beat started during table clear")
	`LLST_ASSERT_SAME(a_start_slot_free, q_pop, !out_valid_q, "beat started with result pending")
	`LLST_ASSERT_NEXT(a_exec_one_cycle, exec, (state_q == B_IDLE) && out_valid_q, "update not done")
	`LLST_ASSERT_SAME(a_took_matches, out_valid_q && res_q.took_over, (res_q.best_server == res_q.server_index) && (res_q.best_count == res_q.server_count), "take-over record mismatch")

endmodule

FILE: design/least_loaded_server_tracker_unit.sv
// the front takes a new address only once it is back in idle after multiply,
// back-multiply and subtract, queue write; a result left unpopped stalls the back end, then the front
// the table read-modify-write, a read state then a write state, overlaps the next reduction
// reset: after arst_n a clearing pass zeroes the tables, one entry a cycle,
// with full held high until it is done
module least_loaded_server_tracker_unit #(
	parameter int SERVERS = 64,
	parameter int GROUPS  = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [31:0] dest_ip,
	input  logic        pop,
	output logic        empty,
	output logic [5:0]  server_index,
	output logic [3:0]  group_index,
	output logic [31:0] server_count,
	output logic [5:0]  best_server,
	output logic [31:0] best_count,
	output logic        took_over
);

	localparam int SRV_W = SERVERS > 1 ? $clog2(SERVERS) : 1;
	localparam int GRP_W = GROUPS > 1 ? $clog2(GROUPS) : 1;
	localparam int Q_W   = SRV_W + GRP_W;

	llst_pkg::q_status_t q_status;
	llst_pkg::result_t   result;
	logic                q_push;
	logic                q_pop;
	logic [Q_W-1:0]      q_wdata;
	logic [Q_W-1:0]      q_rdata;
	logic                clearing;

	llst_front #(
		.SERVERS (SERVERS),
		.GROUPS  (GROUPS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.dest_ip  (dest_ip),
		.clearing (clearing),
		.full     (full),
		.q_status (q_status),
		.q_push   (q_push),
		.q_data   (q_wdata)
	);

	llst_queue #(
		.WIDTH (Q_W)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.pop    (q_pop),
		.rdata  (q_rdata),
		.status (q_status)
	);

	llst_back #(
		.SERVERS (SERVERS),
		.GROUPS  (GROUPS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_status (q_status),
		.q_data   (q_rdata),
		.q_pop    (q_pop),
		.clearing (clearing),
		.pop      (pop),
		.empty    (empty),
		.result   (result)
	);

	assign server_index = result.server_index;
	assign group_index  = result.group_index;
	assign server_count = result.server_count;
	assign best_server  = result.best_server;
	assign best_count   = result.best_count;
	assign took_over    = result.took_over;

endmodule
